// File: src/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

	localparam int DEPTH      = 64;
	localparam int START_SIZE = 8;
	localparam int AW         = $clog2(DEPTH);
	localparam int CW         = AW + 1;
	localparam int LW         = 6;
	localparam int FW         = 3;
	localparam int DW         = 32;

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic [LW-1:0] len_t;
	typedef logic [FW-1:0] func_t;

	localparam func_t FUNC_ALLOC = 3'd0;
	localparam func_t FUNC_DATA  = 3'd1;
	localparam func_t FUNC_FREE  = 3'd2;
	localparam func_t FUNC_READ  = 3'd3;
	localparam func_t FUNC_USAGE = 3'd4;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_NOSPACE = 1'b1;

endpackage

`default_nettype wire

// File: src/ffba_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ffba_req_if;
	import ffba_pkg::*;

	logic                 valid;
	logic                 ready;
	func_t                func;
	len_t                 length;
	addr_t                block_address;
	logic signed [DW-1:0] value;

	modport source (output valid, func, length, block_address, value, input ready);
	modport sink (input valid, func, length, block_address, value, output ready);

endinterface

`default_nettype wire

// File: src/ffba_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ffba_rsp_if;
	import ffba_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 status;
	addr_t                address;
	logic signed [DW-1:0] word;
	cnt_t                 used_words;
	cnt_t                 window_words;
	logic                 last;

	modport source (output valid, status, address, word, used_words, window_words, last,
		input ready);
	modport sink (input valid, status, address, word, used_words, window_words, last,
		output ready);

endinterface

`default_nettype wire

// File: src/first_fit_block_allocator.sv
// First-fit allocator over a 64-word store, each block a length header plus payload words.
// Requests arrive on req as valid/ready beats: alloc, data word, free, read block, usage.
// Results leave on rsp as valid/ready beats; last marks the final beat of one request.
// Alloc walks the header memory from word zero, one header per cycle, jumping over live
// blocks, then doubles the window as needed, writes the header and presents the result.
// A zero length skips the scan. A data word is taken while idle. Free reads the header,
// then, unless no block starts there, walks the active window one header per cycle to
// decide on shrinking. A block read fetches the header, then for each payload word passes
// an issue state and a data state, as the payload memory read is registered. Usage goes
// straight to the result state.
// Only one request is worked on at a time; req is ready when the block is idle, even while
// a finished result still waits in the rsp register.
// When the receiver stalls, the result is held in the output register and the next result
// waits; a read block stalls between its beats.
// Reset clears all headers through per-word valid bits at once, zeroes the used count and
// the pending fill, and sets the window to 8 words; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator (
	input  logic        clk,
	input  logic        arst_n,
	ffba_req_if.sink    req,
	ffba_rsp_if.source  rsp
);
	import ffba_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SCAN   = 4'd1;
	localparam logic [3:0] ST_GROW   = 4'd2;
	localparam logic [3:0] ST_EMIT   = 4'd3;
	localparam logic [3:0] ST_FHDR   = 4'd4;
	localparam logic [3:0] ST_CSTART = 4'd5;
	localparam logic [3:0] ST_CSCAN  = 4'd6;
	localparam logic [3:0] ST_RHDR   = 4'd7;
	localparam logic [3:0] ST_RISSUE = 4'd8;
	localparam logic [3:0] ST_RDATA  = 4'd9;

	logic [3:0] state_q;

	len_t       hdr_mem [DEPTH];
	len_t       hdr_rdata_q;
	logic [DEPTH-1:0] hdr_vld_q;
	logic       hdr_rvld_q;
	addr_t      hdr_raddr;
	logic       hdr_we;

	logic signed [DW-1:0] pl_mem [DEPTH];
	logic signed [DW-1:0] pl_rdata_q;
	logic       pl_we;

	cnt_t       used_q;
	cnt_t       win_q;
	cnt_t       fp_q;
	len_t       rem_q;

	cnt_t       idx_q;
	cnt_t       run_q;
	cnt_t       end_q;
	cnt_t       ptr_q;
	len_t       len_q;
	len_t       cnt_q;
	addr_t      addr_q;
	addr_t      pos_q;
	logic       res_status_q;
	addr_t      res_addr_q;

	logic                 rsp_valid_q;
	logic                 rsp_status_q;
	addr_t                rsp_address_q;
	logic signed [DW-1:0] rsp_word_q;
	cnt_t                 rsp_used_q;
	cnt_t                 rsp_window_q;
	logic                 rsp_last_q;

	logic       req_acc;
	logic       out_free;
	logic       rsp_load;
	len_t       h;
	cnt_t       idx_n;
	cnt_t       run_n;
	cnt_t       need;
	logic       found;
	cnt_t       sub;
	cnt_t       end_n;
	logic [CW:0] dbl;
	cnt_t       grow_w;
	cnt_t       half_w;
	logic       fill_ok;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign rsp_load  = ((state_q == ST_EMIT) || (state_q == ST_RDATA)) && out_free;

	assign h      = hdr_rvld_q ? hdr_rdata_q : '0;
	assign idx_n  = idx_q + CW'(h) + CW'(1);
	assign run_n  = (h == '0) ? run_q + CW'(1) : '0;
	assign need   = CW'(len_q) + CW'(1);
	assign found  = (h == '0) && (run_n == need);
	assign sub    = CW'(h) + CW'(1);
	assign end_n  = (h != '0) ? idx_n : end_q;
	assign dbl    = {win_q, 1'b0};
	assign grow_w = (dbl > (CW+1)'(DEPTH)) ? CW'(DEPTH) : dbl[CW-1:0];
	assign half_w = (win_q >> 1) < CW'(START_SIZE) ? CW'(START_SIZE) : (win_q >> 1);
	assign fill_ok = (rem_q != '0) && (fp_q < CW'(DEPTH));

	assign hdr_we = (state_q == ST_GROW) && (end_q < win_q);
	assign pl_we  = req_acc && (req.func == FUNC_DATA) && fill_ok;

	always_comb begin
		unique case (state_q)
			ST_IDLE:           hdr_raddr = (req.func == FUNC_ALLOC) ? '0 : req.block_address;
			ST_SCAN, ST_CSCAN: hdr_raddr = idx_n[AW-1:0];
			ST_CSTART:         hdr_raddr = '0;
			default:           hdr_raddr = addr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[pos_q] <= len_q;
		end
		hdr_rdata_q <= hdr_mem[hdr_raddr];
		hdr_rvld_q  <= hdr_vld_q[hdr_raddr];
	end

	always_ff @(posedge clk) begin
		if (pl_we) begin
			pl_mem[fp_q[AW-1:0]] <= req.value;
		end
		pl_rdata_q <= pl_mem[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hdr_vld_q   <= '0;
			used_q      <= '0;
			win_q       <= CW'(START_SIZE);
			fp_q        <= '0;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.func == FUNC_DATA) begin
							if (fill_ok) begin
								fp_q  <= fp_q + CW'(1);
								rem_q <= rem_q - LW'(1);
							end
						end else begin
							rem_q <= '0;
							unique case (req.func)
								FUNC_ALLOC: state_q <= (req.length == '0) ? ST_EMIT : ST_SCAN;
								FUNC_FREE:  state_q <= ST_FHDR;
								FUNC_READ:  state_q <= ST_RHDR;
								FUNC_USAGE: state_q <= ST_EMIT;
								default:    state_q <= ST_IDLE;
							endcase
						end
					end
				end
				ST_SCAN: begin
					if (found) begin
						state_q <= ST_GROW;
					end else if (idx_n >= CW'(DEPTH)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_GROW: begin
					if (end_q >= win_q) begin
						win_q <= grow_w;
					end else begin
						hdr_vld_q[pos_q] <= 1'b1;
						used_q  <= used_q + need;
						fp_q    <= CW'(pos_q) + CW'(1);
						rem_q   <= len_q;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FHDR: begin
					if (h == '0) begin
						state_q <= ST_IDLE;
					end else begin
						used_q            <= (used_q >= sub) ? used_q - sub : '0;
						hdr_vld_q[addr_q] <= 1'b0;
						state_q           <= ST_CSTART;
					end
				end
				ST_CSTART: begin
					state_q <= ST_CSCAN;
				end
				ST_CSCAN: begin
					if (idx_n >= win_q) begin
						if (end_n <= (win_q >> 2) && win_q > CW'(START_SIZE)) begin
							win_q <= half_w;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_RHDR: begin
					state_q <= (h == '0) ? ST_IDLE : ST_RISSUE;
				end
				ST_RISSUE: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					if (out_free) begin
						state_q <= (cnt_q == LW'(1)) ? ST_IDLE : ST_RISSUE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					len_q        <= req.length;
					addr_q       <= req.block_address;
					idx_q        <= '0;
					run_q        <= '0;
					end_q        <= '0;
					res_addr_q   <= '0;
					res_status_q <= (req.func == FUNC_ALLOC && req.length == '0) ?
						STATUS_NOSPACE : STATUS_OK;
				end
			end
			ST_SCAN: begin
				idx_q <= idx_n;
				run_q <= run_n;
				if (found) begin
					pos_q <= addr_t'(idx_q - CW'(len_q));
					end_q <= idx_q;
				end else if (idx_n >= CW'(DEPTH)) begin
					res_status_q <= STATUS_NOSPACE;
				end
			end
			ST_GROW: begin
				if (end_q < win_q) begin
					res_addr_q <= pos_q;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					rsp_status_q  <= res_status_q;
					rsp_address_q <= res_addr_q;
					rsp_word_q    <= '0;
					rsp_used_q    <= used_q;
					rsp_window_q  <= win_q;
					rsp_last_q    <= 1'b1;
				end
			end
			ST_CSTART: begin
				idx_q <= '0;
				end_q <= '0;
			end
			ST_CSCAN: begin
				idx_q <= idx_n;
				end_q <= end_n;
			end
			ST_RHDR: begin
				cnt_q <= h;
				ptr_q <= CW'(addr_q) + CW'(1);
			end
			ST_RDATA: begin
				if (out_free) begin
					rsp_status_q  <= STATUS_OK;
					rsp_address_q <= addr_q;
					rsp_word_q    <= (ptr_q < CW'(DEPTH)) ? pl_rdata_q : '0;
					rsp_used_q    <= used_q;
					rsp_window_q  <= win_q;
					rsp_last_q    <= (cnt_q == LW'(1));
					cnt_q         <= cnt_q - LW'(1);
					ptr_q         <= ptr_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.address      = rsp_address_q;
	assign rsp.word         = rsp_word_q;
	assign rsp.used_words   = rsp_used_q;
	assign rsp.window_words = rsp_window_q;
	assign rsp.last         = rsp_last_q;

endmodule

`default_nettype wire

// File: src/ffba_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ffba_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  rsp_status,
	input ffba_pkg::addr_t       rsp_address,
	input logic signed [31:0]    rsp_word,
	input ffba_pkg::cnt_t        rsp_used_words,
	input ffba_pkg::cnt_t        rsp_window_words,
	input logic                  rsp_last
);
	import ffba_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_nospace_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_address == '0 && rsp_word == '0 && rsp_last)
		else $error("no-space result is malformed");

	a_window_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot(rsp_window_words) && rsp_window_words >= cnt_t'(START_SIZE)
			&& rsp_window_words <= cnt_t'(DEPTH))
		else $error("window size out of range");

	a_used_fits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_used_words <= rsp_window_words)
		else $error("used words exceed the window");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_address      (rsp.address),
	.rsp_word         (rsp.word),
	.rsp_used_words   (rsp.used_words),
	.rsp_window_words (rsp.window_words),
	.rsp_last         (rsp.last)
);

`default_nettype wire
